>>> rtl/soe_fractional_history_bank_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fractional history bank
// Implication checks sampled on clk_i, switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SOE_FRACTIONAL_HISTORY_BANK_ASSERT_SVH
`define SOE_FRACTIONAL_HISTORY_BANK_ASSERT_SVH

// same-cycle implication
`define SOE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SOE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/soe_pkg.sv
// ----------------------------------------------------------------------------
// soe_pkg
// Sizes, codes, job type and saturation helper of the fractional history bank.
// ----------------------------------------------------------------------------
package soe_pkg;

  localparam int POINTS     = 1024;
  localparam int RANK       = 4;

  localparam int POINT_W    = 10;
  localparam int DERIV_W    = 24;
  localparam int GAIN_W     = 24;
  localparam int DECAY_W    = 16;
  localparam int NUM_DECAY  = 7;
  localparam int HIST_W     = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;
  localparam int DIDX_W     = $clog2(NUM_DECAY);

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY0 = 3'd1;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam int ENTRIES    = POINTS * RANK;
  localparam int ADDR_W     = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(RANK + 1);

  // gain term: Q0.24 * Q12.12 -> Q12.36, rounded to nearest on the Q16.16 scale
  localparam int PGAIN_W    = GAIN_W + 1 + DERIV_W;
  localparam int INC_SHIFT  = 20;
  localparam int INC_W      = PGAIN_W - INC_SHIFT;

  // decay term: Q0.16 * Q16.16, rounded back to Q16.16
  localparam int PDEC_W     = DECAY_W + 1 + HIST_W;
  localparam int DEC_SHIFT  = 16;
  localparam int DEC_W      = PDEC_W - DEC_SHIFT;

  localparam int UPD_W      = ((DEC_W > INC_W) ? DEC_W : INC_W) + 1;
  localparam int SUM_W      = HIST_W + $clog2(RANK + 1);
  localparam int SAT_W      = (UPD_W > SUM_W) ? UPD_W : SUM_W;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic [NUM_DECAY-1:0][DECAY_W-1:0] decay_vec_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic                      mode;
    logic                      in_range;
    logic [POINT_W-1:0]        point;
    logic signed [INC_W-1:0]   inc_re;
    logic signed [INC_W-1:0]   inc_im;
  } soe_job_t;

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [SAT_W-1:0] v);
    logic signed [HIST_W-1:0] res;
    if (v[SAT_W-1:HIST_W-1] == '0 || v[SAT_W-1:HIST_W-1] == '1) begin
      res = v[HIST_W-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> rtl/soe_if.sv
// ----------------------------------------------------------------------------
// soe_in_if / soe_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface soe_in_if import soe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [POINT_W-1:0]        point;
  logic signed [DERIV_W-1:0] deriv_re;
  logic signed [DERIV_W-1:0] deriv_im;

  modport source (output valid, mode, point, deriv_re, deriv_im, input ready);
  modport sink   (input valid, mode, point, deriv_re, deriv_im, output ready);
endinterface

interface soe_out_if import soe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [POINT_W-1:0]       point_out;
  logic signed [HIST_W-1:0] sum_re;
  logic signed [HIST_W-1:0] sum_im;

  modport source (output valid, point_out, sum_re, sum_im, input ready);
  modport sink   (input valid, point_out, sum_re, sum_im, output ready);
endinterface

>>> rtl/soe_front.sv
// ----------------------------------------------------------------------------
// soe_front
// Accept items, check the point range and form the rounded gain terms.
// ----------------------------------------------------------------------------
module soe_front import soe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [GAIN_W-1:0] gain_i,
  input  logic              clearing_i,
  soe_in_if.sink            in_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output soe_job_t          job_o
);

  localparam logic signed [PGAIN_W-1:0] INC_HALF = PGAIN_W'(1) << (INC_SHIFT - 1);

  logic                      s1_q;
  logic                      s1_mode_q;
  logic                      s1_range_q;
  logic [POINT_W-1:0]        s1_point_q;
  logic signed [PGAIN_W-1:0] s1_prod_re_q;
  logic signed [PGAIN_W-1:0] s1_prod_im_q;
  logic signed [PGAIN_W-1:0] rnd_re;
  logic signed [PGAIN_W-1:0] rnd_im;
  logic                      accept;

  assign in_i.ready = !clearing_i && (!s1_q || job_ready_i);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q         <= 1'b0;
      s1_mode_q    <= MODE_UPDATE;
      s1_range_q   <= 1'b0;
      s1_point_q   <= '0;
      s1_prod_re_q <= '0;
      s1_prod_im_q <= '0;
    end else if (accept) begin
      s1_q         <= 1'b1;
      s1_mode_q    <= in_i.mode;
      s1_range_q   <= 32'(in_i.point) < POINTS;
      s1_point_q   <= in_i.point;
      s1_prod_re_q <= $signed({1'b0, gain_i}) * in_i.deriv_re;
      s1_prod_im_q <= $signed({1'b0, gain_i}) * in_i.deriv_im;
    end else if (job_ready_i) begin
      s1_q <= 1'b0;
    end
  end

  // round to nearest, ties upward
  assign rnd_re = s1_prod_re_q + INC_HALF;
  assign rnd_im = s1_prod_im_q + INC_HALF;

  assign job_valid_o     = s1_q;
  assign job_o.mode      = s1_mode_q;
  assign job_o.in_range  = s1_range_q;
  assign job_o.point     = s1_point_q;
  assign job_o.inc_re    = rnd_re[PGAIN_W-1:INC_SHIFT];
  assign job_o.inc_im    = rnd_im[PGAIN_W-1:INC_SHIFT];

endmodule

>>> rtl/soe_queue.sv
// ----------------------------------------------------------------------------
// soe_queue
// Short job queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module soe_queue import soe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  soe_job_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output soe_job_t pop_data_o
);

  soe_job_t            slot_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                push;
  logic                pop;

  assign push_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/soe_back.sv
// ----------------------------------------------------------------------------
// soe_back
// Run the accumulator updates of one job against the bank memory and sum.
// ----------------------------------------------------------------------------
`include "soe_fractional_history_bank_assert.svh"

module soe_back import soe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  decay_vec_t decay_i,
  output logic       clearing_o,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  soe_job_t   job_i,
  soe_out_if.source  out_o
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_OUT} state_e;

  localparam logic signed [PDEC_W-1:0] DEC_HALF = PDEC_W'(1) << (DEC_SHIFT - 1);
  localparam int MEM_W = 2 * HIST_W;

  logic [MEM_W-1:0] bank_mem [ENTRIES];

  state_e                   state_q;
  logic [ADDR_W-1:0]        clr_q;
  soe_job_t                 job_q;
  logic [ADDR_W-1:0]        base_q;
  logic [CNT_W-1:0]         iss_q;
  logic [CNT_W-1:0]         ret_q;
  logic                     t1_q;
  logic [DIDX_W-1:0]        t1_r_q;
  logic [ADDR_W-1:0]        t1_addr_q;
  logic [MEM_W-1:0]         rd_q;
  logic                     t2_q;
  logic [ADDR_W-1:0]        t2_addr_q;
  logic signed [PDEC_W-1:0] prod_re_q;
  logic signed [PDEC_W-1:0] prod_im_q;
  logic signed [HIST_W-1:0] old_re_q;
  logic signed [HIST_W-1:0] old_im_q;
  logic signed [SUM_W-1:0]  acc_re_q;
  logic signed [SUM_W-1:0]  acc_im_q;
  logic                     out_valid_q;
  logic [POINT_W-1:0]       out_point_q;
  logic signed [HIST_W-1:0] out_re_q;
  logic signed [HIST_W-1:0] out_im_q;

  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [MEM_W-1:0]         mem_wdata;
  logic signed [PDEC_W-1:0] dec_rnd_re;
  logic signed [PDEC_W-1:0] dec_rnd_im;
  logic signed [DEC_W-1:0]  dec_re;
  logic signed [DEC_W-1:0]  dec_im;
  logic signed [UPD_W-1:0]  upd_re;
  logic signed [UPD_W-1:0]  upd_im;
  logic signed [HIST_W-1:0] new_re;
  logic signed [HIST_W-1:0] new_im;
  logic signed [HIST_W-1:0] add_re;
  logic signed [HIST_W-1:0] add_im;
  logic [DECAY_W-1:0]       dec_sel;

  assign clearing_o  = state_q == ST_CLEAR;
  assign job_ready_o = state_q == ST_IDLE;

  assign rd_en   = (state_q == ST_RUN) && (iss_q < CNT_W'(RANK));
  assign rd_addr = base_q + ADDR_W'(iss_q);
  assign dec_sel = decay_i[t1_r_q];

  // writeback stage: round the decay term, add the gain term, saturate, pick the summed value
  always_comb begin
    dec_rnd_re = prod_re_q + DEC_HALF;
    dec_rnd_im = prod_im_q + DEC_HALF;
    dec_re     = dec_rnd_re[PDEC_W-1:DEC_SHIFT];
    dec_im     = dec_rnd_im[PDEC_W-1:DEC_SHIFT];
    upd_re     = UPD_W'(dec_re) + UPD_W'(job_q.inc_re);
    upd_im     = UPD_W'(dec_im) + UPD_W'(job_q.inc_im);
    new_re     = sat_hist(SAT_W'(upd_re));
    new_im     = sat_hist(SAT_W'(upd_im));
    add_re     = (job_q.mode == MODE_READ) ? old_re_q : new_re;
    add_im     = (job_q.mode == MODE_READ) ? old_im_q : new_im;
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = t2_q && (job_q.mode == MODE_UPDATE);
      mem_waddr = t2_addr_q;
      mem_wdata = {new_im, new_re};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bank_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= bank_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      job_q       <= '0;
      base_q      <= '0;
      iss_q       <= '0;
      ret_q       <= '0;
      t1_q        <= 1'b0;
      t1_r_q      <= '0;
      t1_addr_q   <= '0;
      t2_q        <= 1'b0;
      t2_addr_q   <= '0;
      prod_re_q   <= '0;
      prod_im_q   <= '0;
      old_re_q    <= '0;
      old_im_q    <= '0;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      out_valid_q <= 1'b0;
      out_point_q <= '0;
      out_re_q    <= '0;
      out_im_q    <= '0;
    end else begin
      // read and multiply stages advance every cycle
      t1_q      <= rd_en;
      t1_r_q    <= DIDX_W'(iss_q);
      t1_addr_q <= rd_addr;
      t2_q      <= t1_q;
      if (t1_q) begin
        prod_re_q <= $signed({1'b0, dec_sel}) * $signed(rd_q[HIST_W-1:0]);
        prod_im_q <= $signed({1'b0, dec_sel}) * $signed(rd_q[MEM_W-1:HIST_W]);
        old_re_q  <= rd_q[HIST_W-1:0];
        old_im_q  <= rd_q[MEM_W-1:HIST_W];
        t2_addr_q <= t1_addr_q;
      end
      // the output state reloads the result register itself
      if (out_o.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(ENTRIES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q    <= job_i;
            base_q   <= ADDR_W'(ADDR_W'(job_i.point) * ADDR_W'(RANK));
            iss_q    <= '0;
            ret_q    <= '0;
            acc_re_q <= '0;
            acc_im_q <= '0;
            state_q  <= job_i.in_range ? ST_RUN : ST_OUT;
          end
        end
        ST_RUN: begin
          if (rd_en) begin
            iss_q <= iss_q + 1'b1;
          end
          if (t2_q) begin
            acc_re_q <= acc_re_q + SUM_W'(add_re);
            acc_im_q <= acc_im_q + SUM_W'(add_im);
            ret_q    <= ret_q + 1'b1;
            if (ret_q == CNT_W'(RANK - 1)) begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          // hold until the result register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_point_q <= job_q.point;
            out_re_q    <= sat_hist(SAT_W'(acc_re_q));
            out_im_q    <= sat_hist(SAT_W'(acc_im_q));
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.point_out = out_point_q;
  assign out_o.sum_re    = out_re_q;
  assign out_o.sum_im    = out_im_q;

  `SOE_ASSERT_IMP(a_read_mode_no_write, state_q == ST_RUN && job_q.mode == MODE_READ, !mem_we, "read-only item wrote the bank")
  `SOE_ASSERT_IMP(a_pipe_drained, state_q == ST_OUT, !t1_q && !t2_q, "result formed with accumulators in flight")
  `SOE_ASSERT_IMP(a_retire_bound, state_q == ST_RUN, ret_q < CNT_W'(RANK) && iss_q >= ret_q, "retire count ran past issue count or rank")
  `SOE_ASSERT_NXT(a_range_skip, state_q == ST_IDLE && job_valid_i && !job_i.in_range, state_q == ST_OUT && !t1_q, "out-of-range point touched the bank")

endmodule

>>> rtl/soe_fractional_history_bank.sv
// ----------------------------------------------------------------------------
// soe_fractional_history_bank
// Sum-of-exponentials history bank: per-point complex recursive accumulators.
// ----------------------------------------------------------------------------
// Each of POINTS grid points owns RANK complex Q16.16 accumulators, held in a
// single-port-write, single-port-read memory of POINTS*RANK 64-bit words. An
// item in update mode replaces every accumulator r of its point by
// decay_r*old + input_gain*derivative (each term rounded, the sum saturated),
// then reports the saturated bank sum; in read mode it only reports the sum.
// A point beyond the bank reports zero and leaves the memory alone.
// After reset a clearing pass zeroes all POINTS*RANK words one word a cycle;
// input ready stays low meanwhile, while configuration writes are taken as
// ever. Configuration is to be written only while the block is idle.
// Flow: the front multiplies the derivative by the gain and hands a job to a
// two-deep queue; the back then reads, multiplies and writes back one
// accumulator a cycle through a three-stage memory pipeline and drains it
// before the next job; an out-of-range item goes straight to the result. Front
// and queue hold up to three further items, and the result register lets the
// next item proceed while a finished result still waits on out_o.ready.
// ----------------------------------------------------------------------------
module soe_fractional_history_bank import soe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  soe_in_if.sink                in_i,
  soe_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [GAIN_W-1:0] gain_q;
  decay_vec_t        decay_q;
  logic [DIDX_W-1:0] decay_idx;

  logic              fq_valid;
  logic              fq_ready;
  soe_job_t          fq_job;
  logic              qb_valid;
  logic              qb_ready;
  soe_job_t          qb_job;
  logic              clearing;

  // register index 0 is the gain, the decays follow in order
  assign decay_idx = DIDX_W'(cfg_idx_i - CFG_DECAY0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= '0;
      decay_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GAIN) begin
        gain_q <= cfg_data_i[GAIN_W-1:0];
      end else begin
        decay_q[decay_idx] <= cfg_data_i[DECAY_W-1:0];
      end
    end
  end

  // front: accept, range check, gain multiply and rounding
  soe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .clearing_i  (clearing),
    .in_i        (in_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  // decouple front and back so each can stall on its own
  soe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  // back: bank memory, decay multiply, writeback, sum and result register
  soe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .decay_i     (decay_q),
    .clearing_o  (clearing),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_o       (out_o)
  );

endmodule
